FILE: sv/seb_pkg.sv
package seb_pkg;

   localparam int ADDR_W = 9;
   localparam int OFF_W  = ADDR_W + 1;

   localparam logic OP_EXCHANGE  = 1'b0;
   localparam logic OP_FRAME_END = 1'b1;

   localparam logic [7:0] CMD_WREN      = 8'h06;
   localparam logic [7:0] CMD_RDSR      = 8'h05;
   localparam logic [7:0] CMD_READ      = 8'h03;
   localparam logic [7:0] CMD_WRITE     = 8'h02;
   localparam logic [7:0] CMD_KIND_MASK = 8'hF7;
   localparam int         CMD_ADDR8_BIT = 3;

   localparam logic [7:0] BYTE_IDLE = 8'hFF;
   localparam logic [7:0] BYTE_ERASED = 8'hFF;

   typedef enum logic [3:0] {
      PH_CMD    = 4'b0001,
      PH_ADDR   = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_IGNORE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic       use_ram;
      logic [7:0] data;
   } issue_type;

endpackage

FILE: sv/seb_ram.sv
module seb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/seb_ctrl.sv
module seb_ctrl import seb_pkg::*; #(
   parameter int MEM_DEPTH = 512,
   parameter int PAGE_SIZE = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [7:0]                   req_mosi_byte,
   input  logic                         can_issue,
   output issue_type                    issue,
   output logic                         ram_we,
   output logic [$clog2(MEM_DEPTH)-1:0] ram_waddr,
   output logic [7:0]                   ram_wdata,
   output logic                         ram_re,
   output logic [$clog2(MEM_DEPTH)-1:0] ram_raddr
);

   localparam int IDX_W  = $clog2(MEM_DEPTH);
   localparam int HI_MOD = 256 % PAGE_SIZE;

   function automatic logic [256*ADDR_W-1:0] build_mod_tbl();
      logic [256*ADDR_W-1:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*ADDR_W +: ADDR_W] = ADDR_W'(i % PAGE_SIZE);
      end
      return t;
   endfunction

   localparam logic [256*ADDR_W-1:0] MOD_TBL = build_mod_tbl();

   phase_type          phase_ff, phase_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  off_ff, off_in;
   logic               wel_ff, wel_in;
   logic               wrote_ff, wrote_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;

   logic               accept;
   logic [7:0]         kind_cur;
   logic [7:0]         kind_new;
   logic [ADDR_W-1:0]  addr_raw;
   logic [ADDR_W-1:0]  addr_mod;
   logic [OFF_W-1:0]   off_sum;
   logic [ADDR_W-1:0]  off_new;
   logic [OFF_W-1:0]   off_inc;
   logic [OFF_W-1:0]   off_next;
   logic [ADDR_W-1:0]  page_base;
   logic [OFF_W-1:0]   wr_next;
   logic [OFF_W-1:0]   rd_inc;

   assign req_stall = clr_busy_ff | ~can_issue;
   assign accept    = req_valid & ~req_stall;
   assign kind_cur  = cmd_ff & CMD_KIND_MASK;
   assign kind_new  = req_mosi_byte & CMD_KIND_MASK;

   assign addr_raw = {cmd_ff[CMD_ADDR8_BIT], req_mosi_byte};
   assign addr_mod = ({1'b0, addr_raw} >= OFF_W'(MEM_DEPTH))
                     ? addr_raw - ADDR_W'(MEM_DEPTH) : addr_raw;
   assign off_sum  = {1'b0, MOD_TBL[addr_mod[7:0]*ADDR_W +: ADDR_W]}
                     + (addr_mod[8] ? OFF_W'(HI_MOD) : OFF_W'(0));
   assign off_new  = (off_sum >= OFF_W'(PAGE_SIZE))
                     ? ADDR_W'(off_sum - OFF_W'(PAGE_SIZE)) : ADDR_W'(off_sum);

   assign off_inc   = {1'b0, off_ff} + OFF_W'(1);
   assign off_next  = (off_inc == OFF_W'(PAGE_SIZE)) ? OFF_W'(0) : off_inc;
   assign page_base = addr_ff - off_ff;
   assign wr_next   = {1'b0, page_base} + off_next;
   assign rd_inc    = {1'b0, addr_ff} + OFF_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      off_in      = off_ff;
      wel_in      = wel_ff;
      wrote_in    = wrote_ff;
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      issue       = '0;
      issue.data  = BYTE_IDLE;
      ram_we      = 1'b0;
      ram_waddr   = addr_ff[IDX_W-1:0];
      ram_wdata   = req_mosi_byte;
      ram_re      = 1'b0;
      ram_raddr   = addr_ff[IDX_W-1:0];

      if (clr_busy_ff) begin
         ram_we     = 1'b1;
         ram_waddr  = clr_idx_ff;
         ram_wdata  = BYTE_ERASED;
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(MEM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      if (accept) begin
         if (req_operation == OP_FRAME_END) begin
            if (wrote_ff) begin
               wel_in = 1'b0;
            end
            wrote_in = 1'b0;
            phase_in = PH_CMD;
         end else begin
            issue.valid = 1'b1;
            case (phase_ff)
               PH_CMD: begin
                  cmd_in = req_mosi_byte;
                  if (kind_new == CMD_WREN) begin
                     wel_in   = 1'b1;
                     phase_in = PH_IGNORE;
                  end else if (kind_new == CMD_RDSR) begin
                     phase_in = PH_DATA;
                  end else if (kind_new == CMD_READ || kind_new == CMD_WRITE) begin
                     phase_in = PH_ADDR;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_ADDR: begin
                  addr_in  = addr_mod;
                  off_in   = off_new;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (kind_cur == CMD_RDSR) begin
                     issue.data = {6'b0, wel_ff, 1'b0};
                  end else if (kind_cur == CMD_READ) begin
                     ram_re        = 1'b1;
                     issue.use_ram = 1'b1;
                     addr_in       = (rd_inc == OFF_W'(MEM_DEPTH))
                                     ? ADDR_W'(0) : ADDR_W'(rd_inc);
                  end else if (kind_cur == CMD_WRITE) begin
                     if (wel_ff) begin
                        ram_we   = 1'b1;
                        wrote_in = 1'b1;
                     end
                     if (wr_next >= OFF_W'(MEM_DEPTH)) begin
                        addr_in = page_base;
                        off_in  = '0;
                     end else begin
                        addr_in = ADDR_W'(wr_next);
                        off_in  = ADDR_W'(off_next);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CMD;
         cmd_ff      <= '0;
         addr_ff     <= '0;
         off_ff      <= '0;
         wel_ff      <= 1'b0;
         wrote_ff    <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         cmd_ff      <= cmd_in;
         addr_ff     <= addr_in;
         off_ff      <= off_in;
         wel_ff      <= wel_in;
         wrote_ff    <= wrote_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) wrote_ff |-> wel_ff)
      else $error("write recorded in frame without write-enable latch");

   assert property (@(posedge clock) disable iff (reset)
      (ram_we && !clr_busy_ff) |-> (wel_ff && phase_ff == PH_DATA))
      else $error("array write outside an enabled data phase");

   assert property (@(posedge clock) disable iff (reset)
      (addr_ff < ADDR_W'(MEM_DEPTH)) || (MEM_DEPTH == 512))
      else $error("current address beyond array");

endmodule

FILE: sv/seb_resp.sv
module seb_resp import seb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  issue_type  issue,
   input  logic [7:0] ram_rdata,
   output logic       can_issue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_miso_byte
);

   issue_type  p1_ff, p1_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       advance;

   assign advance   = p1_ff.valid & (~out_valid_ff | ~rsp_stall);
   assign can_issue = ~p1_ff.valid | advance;

   always_comb begin
      p1_in        = p1_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (can_issue) begin
         p1_in = issue;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = p1_ff.use_ram ? ram_rdata : p1_ff.data;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_ff.valid  <= p1_in.valid;
         out_valid_ff <= out_valid_in;
      end
      p1_ff.use_ram <= p1_in.use_ram;
      p1_ff.data    <= p1_in.data;
      out_data_ff   <= out_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_miso_byte = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (p1_ff.valid && p1_ff.use_ram && !advance) |=> $stable(ram_rdata))
      else $error("array read data changed under a held transfer");

endmodule

FILE: sv/spi_eeprom_byte_slave.sv
// Byte-level SPI serial EEPROM slave. Each request transfer is either one
// byte exchanged with select low or the end of a frame; every exchanged
// byte yields one response transfer, a frame end yields none. Commands:
// write enable, read status, read and write, with address bit 8 in command
// bit 3. One request is taken per clock while responses drain. An exchanged
// byte passes the stage register beside the array's registered read port,
// then the output register, which drives the response. A stalled response
// holds the output register; once the stage register is full it holds too
// and requests stall. After reset the array is erased to 0xFF by a clearing
// pass over all MEM_DEPTH entries, during which req_stall stays high.
module spi_eeprom_byte_slave import seb_pkg::*; #(
   parameter int MEM_DEPTH = 512,
   parameter int PAGE_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_mosi_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_miso_byte
);

   localparam int IDX_W = $clog2(MEM_DEPTH);

   issue_type        issue;
   logic             can_issue;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   seb_ctrl #(
      .MEM_DEPTH (MEM_DEPTH),
      .PAGE_SIZE (PAGE_SIZE)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_mosi_byte (req_mosi_byte),
      .can_issue     (can_issue),
      .issue         (issue),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr)
   );

   seb_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   seb_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .ram_rdata     (ram_rdata),
      .can_issue     (can_issue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_miso_byte (rsp_miso_byte)
   );

endmodule

FILE: bench/spi_eeprom_byte_slave_tb.sv
module spi_eeprom_byte_slave_tb;
   import seb_pkg::*;

   localparam int MEM_DEPTH = 512;
   localparam int PAGE_SIZE = 16;
   localparam int CYCLE_LIMIT = 200000;

   class eeprom_shadow;
      logic [7:0] memory_bytes [MEM_DEPTH];
      logic       write_latch;
      phase_type  phase;
      logic [7:0] command;
      logic [8:0] address;
      logic       wrote_data;
      logic [7:0] expected_miso [$];
      int         error_count;

      function new();
         foreach (memory_bytes[i]) memory_bytes[i] = BYTE_ERASED;
         write_latch = 1'b0;
         phase = PH_CMD;
         command = 8'h00;
         address = '0;
         wrote_data = 1'b0;
         error_count = 0;
      endfunction

      task report_mismatch(string msg);
         if (error_count < 100) $display("mismatch: %s", msg);
         error_count++;
      endtask

      function int next_in_page(int a);
         int base;
         int n;
         base = a - (a % PAGE_SIZE);
         n = base + (((a - base) + 1) % PAGE_SIZE);
         if (n >= MEM_DEPTH) n = base;
         return n;
      endfunction

      function void take_request(logic op, logic [7:0] b);
         logic [7:0] kind;
         logic [7:0] miso;
         int a;
         if (op == OP_FRAME_END) begin
            if (wrote_data) write_latch = 1'b0;
            wrote_data = 1'b0;
            phase = PH_CMD;
            return;
         end
         miso = BYTE_IDLE;
         kind = command & CMD_KIND_MASK;
         case (phase)
            PH_CMD: begin
               command = b;
               kind = b & CMD_KIND_MASK;
               if (kind == CMD_WREN) begin
                  write_latch = 1'b1;
                  phase = PH_IGNORE;
               end else if (kind == CMD_RDSR) begin
                  phase = PH_DATA;
               end else if (kind == CMD_READ || kind == CMD_WRITE) begin
                  phase = PH_ADDR;
               end else begin
                  phase = PH_IGNORE;
               end
            end
            PH_ADDR: begin
               a = {command[CMD_ADDR8_BIT], b};
               address = 9'(a % MEM_DEPTH);
               phase = PH_DATA;
            end
            PH_DATA: begin
               a = address;
               if (kind == CMD_RDSR) begin
                  miso = {6'b0, write_latch, 1'b0};
               end else if (kind == CMD_READ) begin
                  miso = memory_bytes[a];
                  address = 9'((a + 1) % MEM_DEPTH);
               end else if (kind == CMD_WRITE) begin
                  if (write_latch) begin
                     memory_bytes[a] = b;
                     wrote_data = 1'b1;
                  end
                  address = 9'(next_in_page(a));
               end
            end
            default: ;
         endcase
         expected_miso.push_back(miso);
      endfunction

      task check_miso(logic [7:0] got);
         logic [7:0] want;
         if (expected_miso.size() == 0) begin
            report_mismatch($sformatf("unexpected miso_byte %h", got));
            return;
         end
         want = expected_miso.pop_front();
         if (got !== want)
            report_mismatch($sformatf("miso_byte %h, expected %h", got, want));
      endtask

      task flag_leftovers();
         if (expected_miso.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_miso.size()));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = OP_EXCHANGE;
   logic [7:0] req_mosi_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_miso_byte;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;
   eeprom_shadow eeprom_model;

   spi_eeprom_byte_slave #(
      .MEM_DEPTH(MEM_DEPTH),
      .PAGE_SIZE(PAGE_SIZE)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_mosi_byte(req_mosi_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_miso_byte(rsp_miso_byte)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) eeprom_model.take_request(req_operation, req_mosi_byte);
         if (rsp_valid && !rsp_stall) eeprom_model.check_miso(rsp_miso_byte);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_mosi_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(OP_EXCHANGE, b);
   endtask

   task automatic end_frame();
      send_item(OP_FRAME_END, 8'($urandom_range(255)));
   endtask

   task automatic random_frame();
      int pick;
      int count;
      logic [7:0] cmd;
      logic [7:0] kind;
      pick = $urandom_range(99);
      if (pick < 5) begin
         send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         return;
      end
      if (pick < 25) cmd = CMD_WREN;
      else if (pick < 35) cmd = CMD_RDSR;
      else if (pick < 60) cmd = CMD_READ;
      else if (pick < 90) cmd = CMD_WRITE;
      else cmd = 8'($urandom_range(255));
      if (pick < 90) cmd[CMD_ADDR8_BIT] = 1'($urandom_range(1));
      kind = cmd & CMD_KIND_MASK;
      if (kind == CMD_WRITE && $urandom_range(3) != 0) begin
         send_byte(CMD_WREN);
         end_frame();
      end
      send_byte(cmd);
      if (kind == CMD_READ || kind == CMD_WRITE) send_byte(8'($urandom_range(255)));
      count = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
      repeat (count) send_byte(8'($urandom_range(255)));
      if ($urandom_range(19) != 0) end_frame();
   endtask

   initial begin
      eeprom_model = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_stall_pct = 51;

      end_frame();
      send_byte(CMD_RDSR); send_byte(8'h00); end_frame();
      send_byte(CMD_WREN | 8'h08); send_byte(8'h00); end_frame();
      send_byte(CMD_RDSR); send_byte(8'hFF); end_frame();
      send_byte(CMD_WRITE | 8'h08); send_byte(8'hFF);
      send_byte(8'hA5); send_byte(8'h5A); end_frame();
      send_byte(CMD_WRITE); send_byte(8'h00); send_byte(8'h00); end_frame();
      send_byte(CMD_READ | 8'h08); send_byte(8'hFF);
      send_byte(8'h00); send_byte(8'h00); end_frame();
      send_byte(8'hFF); send_byte(8'h12); end_frame();

      while (items_sent < 310) random_frame();
      send_idle_pct = 51;
      recv_stall_pct = 10;
      while (items_sent < 590) random_frame();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (items_sent < 870) random_frame();
      req_valid <= 1'b0;

      while (eeprom_model.expected_miso.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      eeprom_model.flag_leftovers();
      if (eeprom_model.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: spi_eeprom_byte_slave.f
sv/seb_pkg.sv
sv/seb_ram.sv
sv/seb_ctrl.sv
sv/seb_resp.sv
sv/spi_eeprom_byte_slave.sv
bench/spi_eeprom_byte_slave_tb.sv
